// ===== rtl/cd_pkg.sv =====
// ----------------------------------------------------------------------------
// cd_pkg
// shared types and constants for the circular deque
// ----------------------------------------------------------------------------
package cd_pkg;

  localparam int unsigned CD_DEPTH = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned Q_DEPTH  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    act_t                     act;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/cd_front.sv =====
// ----------------------------------------------------------------------------
// cd_front
// accepts input items, decodes the action and drops unused codes
// ----------------------------------------------------------------------------
module cd_front
  import cd_pkg::*;
(
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [WORD_W-1:0] in_push_value,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output cmd_t                     cmd
);

  logic act_ok;

  always_comb begin
    case (act_t'(in_action))
      ACT_PUSH_FRONT, ACT_PUSH_REAR, ACT_POP_FRONT, ACT_POP_REAR, ACT_LIST: act_ok = 1'b1;
      default: act_ok = 1'b0;
    endcase
  end

  // unused codes are taken and dropped without a transfer to the queue
  assign in_ready  = cmd_ready || !act_ok;
  assign cmd_valid = in_valid && act_ok;
  assign cmd.act   = act_t'(in_action);
  assign cmd.value = in_push_value;

endmodule

// ===== rtl/cd_queue.sv =====
// ----------------------------------------------------------------------------
// cd_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module cd_queue
  import cd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             ent_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = ent_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? ptr_next(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ptr_next(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/cd_back.sv =====
// ----------------------------------------------------------------------------
// cd_back
// deque store, index state and result register
// ----------------------------------------------------------------------------
module cd_back
  import cd_pkg::*;
#(
  parameter int unsigned DEPTH = CD_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  cmd_t                     cmd,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_data_out,
  output logic                     out_last
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_DATA
  } state_t;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [IDX_W-1:0]         rear_r, rear_nxt;
  logic                     empty_r, empty_nxt;
  logic [IDX_W-1:0]         lst_r, lst_nxt;
  logic                     list_r, list_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0] out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [WORD_W-1:0]        mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;
  logic                     wr_en, rd_en;
  logic [IDX_W-1:0]         wr_addr, rd_addr;
  logic                     slot_free, is_full, at_end, out_load;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    idx_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    idx_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign is_full   = !empty_r && (idx_next(rear_r) == front_r);
  assign at_end    = !list_r || (lst_r == rear_r);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    empty_nxt      = empty_r;
    lst_nxt        = lst_r;
    list_nxt       = list_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = front_r;
    rd_en          = 1'b0;
    rd_addr        = front_r;
    cmd_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd_ready = slot_free;
        if (cmd_valid && slot_free) begin
          case (cmd.act)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              out_load     = 1'b1;
              out_data_nxt = '0;
              out_last_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                wr_en          = 1'b1;
                if (empty_r) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                  empty_nxt = 1'b0;
                  wr_addr   = '0;
                end else if (cmd.act == ACT_PUSH_FRONT) begin
                  front_nxt = idx_prev(front_r);
                  wr_addr   = idx_prev(front_r);
                end else begin
                  rear_nxt = idx_next(rear_r);
                  wr_addr  = idx_next(rear_r);
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
              if (empty_r) begin
                out_load       = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_data_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = (cmd.act == ACT_POP_FRONT) ? front_r : rear_r;
                list_nxt  = 1'b0;
                state_nxt = S_DATA;
                if (front_r == rear_r) begin
                  empty_nxt = 1'b1;
                  front_nxt = '0;
                  rear_nxt  = '0;
                end else if (cmd.act == ACT_POP_FRONT) begin
                  front_nxt = idx_next(front_r);
                end else begin
                  rear_nxt = idx_prev(rear_r);
                end
              end
            end
            ACT_LIST: begin
              if (empty_r) begin
                out_load       = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_data_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                lst_nxt   = front_r;
                list_nxt  = 1'b1;
                state_nxt = S_DATA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = rd_data_r;
          out_last_nxt   = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            lst_nxt = idx_next(lst_r);
            rd_en   = 1'b1;
            rd_addr = idx_next(lst_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      list_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      list_r      <= list_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lst_r        <= lst_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

`ifndef NO_ASSERTIONS
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (front_r == '0) && (rear_r == '0))
    else $error("empty deque with nonzero index");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r <= IDX_W'(DEPTH - 1)) && (rear_r <= IDX_W'(DEPTH - 1)))
    else $error("deque index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load)
    else $error("result register loaded while held");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA && list_r) |-> !empty_r)
    else $error("listing an empty deque");

  a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |-> !cmd_ready)
    else $error("command taken during data phase");
`endif

endmodule

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of signed words in a circular store
//
// channel  ports                                                 direction
// in       in_valid/in_ready, in_action, in_push_value           input
// out      out_valid/out_ready, out_status, out_data_out, out_last  output
//
// push and error results: an entry of the two-entry command queue, then the
// result register of the back stage
// pop: the command queue entry, the registered read of the store, then the
// result register of the back stage
// list: a registered store read, then one word per cycle while out_ready is high
// reset is synchronous; no clearing pass, the store needs none
// a held result stalls the back stage; the queue keeps taking input until full
// ----------------------------------------------------------------------------
module circular_deque
  import cd_pkg::*;
#(
  parameter int unsigned DEPTH = CD_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [WORD_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_data_out,
  output logic                     out_last
);

  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  cd_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_push_value (in_push_value),
    .cmd_valid     (fq_valid),
    .cmd_ready     (fq_ready),
    .cmd           (fq_cmd)
  );

  cd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  cd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (qb_valid),
    .cmd_ready    (qb_ready),
    .cmd          (qb_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

endmodule

// ===== test/deque_checker.sv =====
// ----------------------------------------------------------------------------
// deque_checker
// watches both channels of the circular deque, keeps its own copy of the
// queue contents and compares every result transfer with the oldest one due
// ----------------------------------------------------------------------------
module deque_checker
  import cd_pkg::*;
#(
  parameter int unsigned DEPTH = CD_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [WORD_W-1:0] in_push_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STAT_W-1:0]        out_status,
  input  logic signed [WORD_W-1:0] out_data_out,
  input  logic                     out_last,
  output int unsigned              mismatches,
  output int unsigned              waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] data;
    logic              last;
  } result_t;

  logic [WORD_W-1:0] slots [DEPTH];
  int unsigned       head;
  int unsigned       tail;
  bit                vacant;
  result_t           due_results [$];

  function automatic int unsigned next_slot(input int unsigned i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int unsigned prev_slot(input int unsigned i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic expect_result(input status_t st, input logic [WORD_W-1:0] data,
                               input logic last);
    result_t r;
    r.status = st;
    r.data   = data;
    r.last   = last;
    due_results.push_back(r);
  endtask

  // one input transfer: update the queue copy and queue up its results
  task automatic apply_action(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
    int unsigned       idx;
    logic [WORD_W-1:0] word;
    bit                done;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (!vacant && next_slot(tail) == head) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          if (vacant) begin
            head     = 0;
            tail     = 0;
            vacant   = 1'b0;
            slots[0] = val;
          end else if (act == ACT_PUSH_FRONT) begin
            head        = prev_slot(head);
            slots[head] = val;
          end else begin
            tail        = next_slot(tail);
            slots[tail] = val;
          end
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (vacant) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          word = (act == ACT_POP_FRONT) ? slots[head] : slots[tail];
          if (head == tail) begin
            vacant = 1'b1;
            head   = 0;
            tail   = 0;
          end else if (act == ACT_POP_FRONT) begin
            head = next_slot(head);
          end else begin
            tail = prev_slot(tail);
          end
          expect_result(ST_OK, word, 1'b1);
        end
      end
      ACT_LIST: begin
        if (vacant) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx  = head;
          done = 1'b0;
          while (!done) begin
            done = (idx == tail);
            expect_result(ST_OK, slots[idx], done);
            idx = next_slot(idx);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result: status %0d data %h last %b",
                                out_status, out_data_out, out_last));
    end else begin
      want = due_results.pop_front();
      if (out_status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
      if (out_data_out !== want.data) begin
        report_mismatch($sformatf("data_out %h, expected %h", out_data_out, want.data));
      end
      if (out_last !== want.last) begin
        report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head   = 0;
      tail   = 0;
      vacant = 1'b1;
      due_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        apply_action(in_action, in_push_value);
      end
      if (out_valid && out_ready) begin
        check_result();
      end
    end
    waiting = due_results.size();
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives the circular deque with a directed opening (empty and full corners,
// single-word pops from either end, wrap of the indices, spare action codes)
// and then random traffic that swings between filling and draining, with
// idle and stall bursts on both channels; the checker judges every result
// ----------------------------------------------------------------------------
module tb
  import cd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned      RANDOM_ITEMS     = 400;
  localparam int unsigned      CALM_ITEMS       = 60;
  localparam int unsigned      SEGMENT          = 40;
  localparam int unsigned      DRAIN_CYCLES     = 40;
  localparam int unsigned      CYCLE_LIMIT      = 2_000_000;
  localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         in_action;
  logic signed [WORD_W-1:0] in_push_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_data_out;
  logic                     out_last;

  int unsigned mismatches;
  int unsigned waiting;
  int unsigned cycle_count;
  int unsigned in_gap_pct = 25;
  int unsigned stall_pct  = 30;
  bit          calm;

  circular_deque #(.DEPTH(CD_DEPTH)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

  deque_checker #(.DEPTH(CD_DEPTH)) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_last     (out_last),
    .mismatches   (mismatches),
    .waiting      (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 25;
      default: return 60;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input bit filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    end else if (r < 15) begin
      return ACT_LIST;
    end else if (r < (filling ? 72 : 36)) begin
      return $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
    end else begin
      return $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
    end
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic send(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_push_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int k;
    bit filling;
    in_valid      <= 1'b0;
    in_action     <= ACT_PUSH_FRONT;
    in_push_value <= '0;
    out_ready     <= 1'b0;
    rst_n         <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue corners
    send(ACT_LIST, pick_value());
    send(ACT_POP_FRONT, pick_value());
    send(ACT_POP_REAR, pick_value());
    // single word out of either end
    send(ACT_PUSH_FRONT, 32'h7fff_ffff);
    send(ACT_POP_REAR, pick_value());
    send(ACT_PUSH_REAR, 32'h8000_0000);
    send(ACT_POP_FRONT, pick_value());
    // fill from both ends, wrapping the indices
    for (k = 0; k < CD_DEPTH; k++) begin
      send(k[0] ? ACT_PUSH_REAR : ACT_PUSH_FRONT, pick_value());
    end
    send(ACT_PUSH_FRONT, pick_value());
    send(ACT_PUSH_REAR, pick_value());
    send(ACT_LIST, pick_value());
    for (k = ACT_UNUSED_FIRST; k <= ACT_UNUSED_LAST; k++) begin
      send(k[ACT_W-1:0], pick_value());
    end

    filling = 1'b1;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % SEGMENT == 0) begin
        filling    = ~filling;
        in_gap_pct = pick_pct();
        stall_pct  = pick_pct();
      end
      if (k == RANDOM_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      send(pick_action(filling), pick_value());
    end
    in_valid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
